// File: hdl/utf8sd_pkg.sv
package utf8sd_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PLAIN     = 2'd0,
        KIND_DECODED   = 2'd1,
        KIND_LONE      = 2'd2,
        KIND_MALFORMED = 2'd3
    } kind_t;

    localparam int RUN_SAT   = 5;     // run length that stands for "more than four bytes"
    localparam int QDEPTH    = 4;     // result queue entries
    localparam int PTR_W     = $clog2(QDEPTH);
    localparam int CNT_W     = $clog2(QDEPTH + 1);
    localparam int VALUE_W   = 21;
    localparam int TAIL_W    = 18;
    localparam int OUT_TDATA_W = 24;

    // One result item
    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               seen;
    } result_t;

    // Results caused by one accepted byte
    typedef struct packed {
        logic [1:0] num;
        result_t    r0;
        result_t    r1;
    } push_t;

    // Decoded view of a pending run
    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
    } run_out_t;

    // Close a run: decode by length, lead byte masked by length, tail bits kept
    function automatic run_out_t flush_run(input logic [7:0] lead,
                                           input logic [TAIL_W-1:0] tail,
                                           input logic [2:0] len);
        run_out_t r;
        unique case (len)
            3'd1:
            begin
                r.kind  = KIND_LONE;
                r.value = {13'd0, lead};
            end
            3'd2:
            begin
                r.kind  = KIND_DECODED;
                r.value = {10'd0, lead[4:0], tail[5:0]};
            end
            3'd3:
            begin
                r.kind  = KIND_DECODED;
                r.value = {5'd0, lead[3:0], tail[11:0]};
            end
            3'd4:
            begin
                r.kind  = KIND_DECODED;
                r.value = {lead[2:0], tail[17:0]};
            end
            default:
            begin
                r.kind  = KIND_MALFORMED;
                r.value = '0;
            end
        endcase
        return r;
    endfunction

endpackage

// File: hdl/utf8sd_core.sv
module utf8sd_core
    import utf8sd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        end_of_text,
    output push_t       push
);

    logic [7:0]        lead_reg, lead_next;
    logic [TAIL_W-1:0] tail_reg, tail_next;
    logic [2:0]        len_reg, len_next;
    logic              flag_reg, flag_next;

    logic              is_high;
    logic              is_lead;
    logic              pending;
    logic              flush_old;
    logic              flush_new;
    logic [7:0]        mid_lead;
    logic [TAIL_W-1:0] mid_tail;
    logic [2:0]        mid_len;
    run_out_t          old_out;
    run_out_t          mid_out;
    result_t           res_old;
    result_t           res_second;

    assign is_high   = data_byte[7];
    assign is_lead   = (data_byte[7:6] == 2'b11);
    assign pending   = (len_reg != 3'd0);
    assign flush_old = pending && (!is_high || is_lead);
    assign flush_new = is_high && end_of_text;
    assign flag_next = flag_reg | is_high;

    // Run after this byte is folded in (high bytes only)
    always_comb
    begin
        if (!pending || is_lead)
        begin
            mid_lead = data_byte;
            mid_tail = '0;
            mid_len  = 3'd1;
        end
        else
        begin
            mid_lead = lead_reg;
            mid_tail = {tail_reg[TAIL_W-7:0], data_byte[5:0]};
            mid_len  = (len_reg < 3'(RUN_SAT)) ? 3'(len_reg + 3'd1) : 3'(RUN_SAT);
        end
    end

    assign old_out = flush_run(lead_reg, tail_reg, len_reg);
    assign mid_out = flush_run(mid_lead, mid_tail, mid_len);

    // Build the result items
    always_comb
    begin
        res_old.kind  = old_out.kind;
        res_old.value = old_out.value;
        res_old.last  = 1'b0;
        res_old.seen  = flag_next;

        if (is_high)
        begin
            res_second.kind  = mid_out.kind;
            res_second.value = mid_out.value;
        end
        else
        begin
            res_second.kind  = KIND_PLAIN;
            res_second.value = {13'd0, data_byte};
        end
        res_second.last = 1'b1;
        res_second.seen = flag_next;

        push.num = 2'd0;
        push.r0  = res_second;
        push.r1  = res_second;
        if (accept)
        begin
            if (flush_old && (!is_high || flush_new))
            begin
                push.num = 2'd2;
                push.r0  = res_old;
            end
            else if (flush_old)
            begin
                push.num = 2'd1;
                push.r0  = res_old;
                push.r0.last = 1'b1;
            end
            else if (!is_high || flush_new)
            begin
                push.num = 2'd1;
            end
        end
    end

    // Next run state
    always_comb
    begin
        lead_next = lead_reg;
        tail_next = tail_reg;
        len_next  = len_reg;
        if (accept)
        begin
            if (!is_high || flush_new)
            begin
                lead_next = '0;
                tail_next = '0;
                len_next  = 3'd0;
            end
            else
            begin
                lead_next = mid_lead;
                tail_next = mid_tail;
                len_next  = mid_len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= '0;
            tail_reg <= '0;
            len_reg  <= 3'd0;
            flag_reg <= 1'b0;
        end
        else
        begin
            lead_reg <= lead_next;
            tail_reg <= tail_next;
            len_reg  <= len_next;
            if (accept)
            begin
                flag_reg <= flag_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        flag_reg |=> flag_reg)
        else $error("non-ASCII flag dropped");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= 3'(RUN_SAT))
        else $error("run length out of range");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_text) |=> (len_reg == 3'd0))
        else $error("run pending after last byte");
`endif

endmodule

// File: hdl/utf8sd_outq.sv
module utf8sd_outq
    import utf8sd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_item
);

    result_t          q_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign room      = (count_reg <= CNT_W'(QDEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_item  = q_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = PTR_W'(wr_ptr_reg + PTR_W'(push.num));
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        count_next  = CNT_W'(count_reg + CNT_W'(push.num) - CNT_W'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, up to two writes per cycle
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.num == 2'd2)
        begin
            q_reg[PTR_W'(wr_ptr_reg + PTR_W'(1))] <= push.r1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != 2'd0) |-> room)
        else $error("push without room");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.num == 2'd0) |=> (count_reg == CNT_W'($past(count_reg) - CNT_W'(1))))
        else $error("fill level wrong after pop");
`endif

endmodule

// File: hdl/utf8_stream_decoder.sv
// Output: a result is registered in the result queue at its byte's transfer.
// Throughput: one byte per cycle while s_tready is high; a byte causes at most
// two results, and the four-entry result queue drains one result per cycle while
// m_tready is high, so s_tready drops when fewer than two entries are free.
// Reset: rst_n is asynchronous, active low; it clears the pending run, the
// non-ASCII flag and the result queue.
module utf8_stream_decoder
    import utf8sd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,   // end_of_text
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [20:0] char_value, [21] seen_non_ascii, zero pad
    output logic                   m_tlast,   // final_of_run
    output logic [1:0]             m_tuser    // [1:0] item_kind
);

    push_t   push;
    result_t out_item;
    logic    room;
    logic    accept;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    utf8sd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (s_tdata),
        .end_of_text (s_tlast),
        .push        (push)
    );

    utf8sd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    // Output packing
    assign m_tdata = {{(OUT_TDATA_W - VALUE_W - 1){1'b0}}, out_item.seen, out_item.value};
    assign m_tlast = out_item.last;
    assign m_tuser = out_item.kind;

endmodule

// File: tb/utf8_result_checker.sv
module utf8_result_checker
    import utf8sd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,    // [7:0] data_byte
    input  logic                   s_tlast,    // end_of_text
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,    // [20:0] char_value, [21] seen_non_ascii
    input  logic                   m_tlast,    // final_of_run
    input  logic [1:0]             m_tuser,    // [1:0] item_kind
    output int                     fail_count,
    output int                     chars_owed,
    output int                     n_checked,
    output int                     n_decoded,
    output int                     n_malformed
);

    timeunit 1ns;
    timeprecision 1ps;

    // Shadow decoder state
    logic [7:0]        run_lead;
    logic [TAIL_W-1:0] run_tail;
    logic [2:0]        run_len;
    logic              seen_flag;

    // Characters predicted but not yet seen on the output
    result_t pending_chars[$];
    result_t want;

    // Close the pending run and clear it
    function automatic result_t close_run();
        result_t     r;
        logic [20:0] lead_w;
        logic [20:0] tail_w;
        lead_w = 21'(run_lead);
        tail_w = 21'(run_tail);
        case (run_len)
            3'd1:
            begin
                r.kind  = KIND_LONE;
                r.value = lead_w;
            end
            3'd2:
            begin
                r.kind  = KIND_DECODED;
                r.value = ((lead_w & 21'h1F) << 6) | (tail_w & 21'h3F);
            end
            3'd3:
            begin
                r.kind  = KIND_DECODED;
                r.value = ((lead_w & 21'h0F) << 12) | (tail_w & 21'hFFF);
            end
            3'd4:
            begin
                r.kind  = KIND_DECODED;
                r.value = ((lead_w & 21'h07) << 18) | (tail_w & 21'h3FFFF);
            end
            default:
            begin
                r.kind  = KIND_MALFORMED;
                r.value = '0;
            end
        endcase
        r.last   = 1'b0;
        r.seen   = seen_flag;
        run_len  = '0;
        run_lead = '0;
        run_tail = '0;
        return r;
    endfunction

    // Work out the characters one accepted byte releases
    task automatic decode_byte(input logic [7:0] b, input logic eot);
        result_t outs [2];
        int      n;
        n = 0;
        if (b[7])
        begin
            seen_flag = 1'b1;
            // a lead byte closes whatever is pending
            if (b[6] && run_len != 0)
            begin
                outs[n] = close_run();
                n++;
            end
            if (run_len == 0)
            begin
                run_lead = b;
                run_tail = '0;
                run_len  = 3'd1;
            end
            else
            begin
                run_tail = {run_tail[TAIL_W-7:0], b[5:0]};
                if (run_len < RUN_SAT)
                    run_len++;
            end
            if (eot)
            begin
                outs[n] = close_run();
                n++;
            end
        end
        else
        begin
            if (run_len != 0)
            begin
                outs[n] = close_run();
                n++;
            end
            outs[n].kind  = KIND_PLAIN;
            outs[n].value = 21'(b);
            outs[n].last  = 1'b0;
            outs[n].seen  = seen_flag;
            n++;
        end
        if (n > 0)
            outs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_chars.insert(pending_chars.size(), outs[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_lead    = '0;
            run_tail    = '0;
            run_len     = '0;
            seen_flag   = 1'b0;
            pending_chars.delete();
            fail_count  = 0;
            chars_owed  = 0;
            n_checked   = 0;
            n_decoded   = 0;
            n_malformed = 0;
        end
        else
        begin
            // output side first: a result never belongs to a byte of this same edge
            if (m_tvalid && m_tready)
            begin
                if (pending_chars.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d value=%h last=%b seen=%b",
                             $time, m_tuser, m_tdata[20:0], m_tlast, m_tdata[21]);
                    fail_count++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (m_tuser !== want.kind || m_tdata[20:0] !== want.value ||
                        m_tlast !== want.last || m_tdata[21] !== want.seen)
                    begin
                        $display("%0t: mismatch expected kind=%0d value=%h last=%b seen=%b",
                                 $time, want.kind, want.value, want.last, want.seen);
                        $display("%0t:          actual   kind=%0d value=%h last=%b seen=%b",
                                 $time, m_tuser, m_tdata[20:0], m_tlast, m_tdata[21]);
                        fail_count++;
                    end
                    if (want.kind == KIND_DECODED)
                        n_decoded++;
                    if (want.kind == KIND_MALFORMED)
                        n_malformed++;
                end
                n_checked++;
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            chars_owed = pending_chars.size();
        end
    end

endmodule

// File: tb/tb_top.sv
module tb_top
    import utf8sd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1450;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 8;

    // {end_of_text, data_byte}
    localparam logic [8:0] DIRECTED [0:24] = '{
        9'h000, 9'h07F,                         // ASCII extremes
        9'h0C3, 9'h0A9,                         // two-byte form
        9'h0E2, 9'h082, 9'h0AC, 9'h041,         // three-byte, closed by ASCII
        9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,         // largest four-byte, flushed on last
        9'h080, 9'h020,                         // continuation with no lead
        9'h0C0, 9'h080, 9'h1FF,                 // overlong, then lead on last byte
        9'h0F8, 9'h080, 9'h080, 9'h080, 9'h080, 9'h080,  // six-byte run
        9'h17E,                                 // ASCII on last byte
        9'h180                                  // lone byte on last byte
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic [1:0]             m_tuser;

    int fail_count;
    int chars_owed;
    int n_checked;
    int n_decoded;
    int n_malformed;
    int bytes_sent   = 0;
    int strings_sent = 0;
    int cycle_count  = 0;
    bit tx_calm      = 1'b0;

    always #5ns clk = ~clk;

    utf8_stream_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    utf8_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .chars_owed  (chars_owed),
        .n_checked   (n_checked),
        .n_decoded   (n_decoded),
        .n_malformed (n_malformed)
    );

    // Idle cycles before the next byte: mostly none, some short, a few long
    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    // One byte transfer; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = tx_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        if (eot)
            strings_sent++;
        @(negedge clk);
    endtask

    // A random string: mostly well-formed characters, some noise and broken runs
    task automatic send_string();
        logic [7:0] text[$];
        int         nchars;
        int         r;
        int         ncont;
        nchars  = $urandom_range(1, 12);
        tx_calm = ($urandom_range(0, 5) == 0);
        for (int c = 0; c < nchars; c++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                text.insert(text.size(), 8'($urandom_range(0, 127)));
            else if (r < 58)
            begin
                text.insert(text.size(), {3'b110, 5'($urandom)});
                text.insert(text.size(), cont_byte());
            end
            else if (r < 72)
            begin
                text.insert(text.size(), {4'b1110, 4'($urandom)});
                repeat (2) text.insert(text.size(), cont_byte());
            end
            else if (r < 84)
            begin
                text.insert(text.size(), {5'b11110, 3'($urandom)});
                repeat (3) text.insert(text.size(), cont_byte());
            end
            else if (r < 90)
                text.insert(text.size(), 8'($urandom_range(0, 255)));
            else if (r < 94)
            begin
                // truncated multibyte character
                text.insert(text.size(), {4'b1110, 4'($urandom)});
                ncont = $urandom_range(0, 1);
                repeat (ncont) text.insert(text.size(), cont_byte());
            end
            else if (r < 97)
            begin
                // stray continuation bytes
                ncont = $urandom_range(1, 2);
                repeat (ncont) text.insert(text.size(), cont_byte());
            end
            else
            begin
                // run of five to seven bytes
                text.insert(text.size(), {2'b11, 6'($urandom)});
                ncont = $urandom_range(4, 6);
                repeat (ncont) text.insert(text.size(), cont_byte());
            end
        end
        for (int j = 0; j < text.size(); j++)
            send_byte(text[j], j == text.size() - 1);
    endtask

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Result sink with random backpressure
    initial
    begin : result_sink
        int hold;
        int beats;
        int r;
        hold     = 0;
        beats    = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            beats++;
            r = $urandom_range(0, 99);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if ((beats / 200) % 4 == 3)
                m_tready <= 1'b1;   // stretch with no stalls
            else if (r < 70)
                m_tready <= 1'b1;
            else if (r < 95)
            begin
                hold     = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
            begin
                hold     = $urandom_range(10, 40);
                m_tready <= 1'b0;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        rst_n    = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < 25; i++)
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

        while (bytes_sent < ITEM_TARGET)
            send_string();
        s_tvalid <= 1'b0;

        // drain, then give stray results time to show up
        while (chars_owed != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("tb_top: %0d bytes in %0d strings, %0d results checked",
                 bytes_sent, strings_sent, n_checked);
        $display("tb_top: %0d multibyte code points, %0d malformed runs",
                 n_decoded, n_malformed);
        if (fail_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// File: files.f
hdl/utf8sd_pkg.sv
hdl/utf8sd_core.sv
hdl/utf8sd_outq.sv
hdl/utf8_stream_decoder.sv
tb/utf8_result_checker.sv
tb/tb_top.sv
